>>> src/button_click_classifier_top_assert.svh
// Assertion macros for the button click classifier.
// Used by the top level; expects a clock named clk and a reset named arst_n.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bcc_pkg.sv
// Shared types and codes for the button click classifier.
// No dependencies; used by the interfaces, the decision core and the top level.
package bcc_pkg;

	localparam int unsigned TimeWidth  = 32;
	localparam int unsigned LevelWidth = 16;
	localparam int unsigned RegWidth   = 16;
	localparam int unsigned AddrWidth  = 5;
	localparam int unsigned DataWidth  = 32;

	// Result codes of one poll.
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_CLICK = 2'd1,
		EV_LONG  = 2'd2,
		EV_AUTO  = 2'd3
	} event_t;

	// Register indexes (word address of the configuration port).
	typedef enum logic [2:0] {
		REG_KEY_LEVEL     = 3'd0,
		REG_BOUNCE_TIME   = 3'd1,
		REG_LONG_TIME     = 3'd2,
		REG_REPEAT_DELAY  = 3'd3,
		REG_REPEAT_PERIOD = 3'd4
	} reg_idx_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [RegWidth-1:0] key_level;
		logic [RegWidth-1:0] bounce_time;
		logic [RegWidth-1:0] long_time;
		logic [RegWidth-1:0] repeat_delay;
		logic [RegWidth-1:0] repeat_period;
	} cfg_t;

	// Key tracking state carried from poll to poll.
	typedef struct packed {
		logic                 held;
		logic                 long_fired;
		logic                 repeat_fired;
		logic [TimeWidth-1:0] release_stamp;
		logic [TimeWidth-1:0] press_stamp;
		logic [TimeWidth-1:0] repeat_stamp;
	} key_state_t;

endpackage

>>> src/bcc_poll_if.sv
// Poll channel: timestamp and converter level, valid/ready handshake.
// Depends on bcc_pkg for field widths.
interface bcc_poll_if import bcc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [TimeWidth-1:0]  now_time;
	logic [LevelWidth-1:0] level;

	modport source (output valid, now_time, level, input ready);
	modport sink (input valid, now_time, level, output ready);
endinterface

>>> src/bcc_event_if.sv
// Event channel: one classification result per poll, valid/ready handshake.
// Depends on bcc_pkg only by convention; the payload is a 2-bit code.
interface bcc_event_if import bcc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] event_res;

	modport source (output valid, event_res, input ready);
	modport sink (input valid, event_res, output ready);
endinterface

>>> src/bcc_core.sv
// Decision logic for one poll: event code and next key state.
// Depends on bcc_pkg for the state, configuration and event types.
module bcc_core import bcc_pkg::*; (
	input  key_state_t            cur,
	input  cfg_t                  cfg,
	input  logic [TimeWidth-1:0]  now_time,
	input  logic [LevelWidth-1:0] level,
	output key_state_t            nxt,
	output event_t                evt
);

	logic                 down;
	logic                 features;
	logic [TimeWidth-1:0] dt_release;
	logic [TimeWidth-1:0] dt_press;
	logic [TimeWidth-1:0] dt_repeat;
	logic                 press_hit;
	logic                 long_hit;
	logic                 auto_hit;
	logic                 release_hit;

	// Key state and wrapping time differences.
	assign down       = (level == cfg.key_level);
	assign features   = (cfg.long_time != '0) || (cfg.repeat_delay != '0);
	assign dt_release = now_time - cur.release_stamp;
	assign dt_press   = now_time - cur.press_stamp;
	assign dt_repeat  = now_time - cur.repeat_stamp;

	// Individual checks, each against the state as it stood before this poll.
	// A press restarts the press timer, so nothing later in the same poll can fire.
	assign press_hit   = down && !cur.held &&
		(dt_release > {{(TimeWidth-RegWidth){1'b0}}, cfg.bounce_time});
	assign long_hit    = down && !cur.long_fired && (cfg.long_time != '0) &&
		(dt_press > {{(TimeWidth-RegWidth){1'b0}}, cfg.long_time});
	assign auto_hit    = down && (cfg.repeat_delay != '0) &&
		(dt_press > {{(TimeWidth-RegWidth){1'b0}}, cfg.repeat_delay}) &&
		(dt_repeat > {{(TimeWidth-RegWidth){1'b0}}, cfg.repeat_period});
	assign release_hit = !down && cur.held &&
		(dt_press > {{(TimeWidth-RegWidth){1'b0}}, cfg.bounce_time});

	// First check that applies decides the event.
	always_comb begin
		nxt = cur;
		evt = EV_NONE;
		if (press_hit) begin
			nxt.held         = 1'b1;
			nxt.long_fired   = 1'b0;
			nxt.repeat_fired = 1'b0;
			nxt.press_stamp  = now_time;
			evt              = features ? EV_NONE : EV_CLICK;
		end else if (long_hit) begin
			nxt.long_fired = 1'b1;
			evt            = EV_LONG;
		end else if (auto_hit) begin
			nxt.repeat_fired = 1'b1;
			nxt.repeat_stamp = now_time;
			evt              = EV_AUTO;
		end else if (release_hit) begin
			nxt.held          = 1'b0;
			nxt.release_stamp = now_time;
			if (features && !cur.long_fired && !cur.repeat_fired) begin
				evt = EV_CLICK;
			end
		end
	end

endmodule

>>> src/button_click_classifier_top.sv
// Top level of the button click classifier: input register, decision core,
// result register and APB configuration registers. Depends on bcc_pkg,
// bcc_poll_if, bcc_event_if, bcc_core and the assertion macro header.

// Each poll transfer carries a millisecond time and a converter level and
// yields exactly one event code (none, click, long press, auto repeat). The
// block accepts one poll per clock cycle while the result register is free or
// its event is being taken. A poll is held in the input register, where the
// key state is read and updated, and its event is loaded into the result
// register when the input stage advances; the event is then presented from the
// result register until it is transferred. Polls are classified strictly
// in order because the key state is updated in that single stage. Configuration
// registers sit at byte addresses 0, 4, 8, 12 and 16 and should be written only
// while no poll is in flight.
module button_click_classifier_top import bcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bcc_poll_if.sink             poll,
	bcc_event_if.source          evt,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready
);

	cfg_t                  cfg_q;
	key_state_t            state_q;
	key_state_t            state_nxt;
	event_t                event_nxt;
	event_t                event_q;
	logic                  out_valid_q;
	logic                  valid_s1;
	logic [TimeWidth-1:0]  now_s1;
	logic [LevelWidth-1:0] level_s1;
	logic                  advance;
	logic                  cfg_write;
	reg_idx_t              cfg_idx;

	// Configuration port: zero wait states, word index from the byte address.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = reg_idx_t'(paddr[AddrWidth-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_level     <= 16'd0;
			cfg_q.bounce_time   <= 16'd50;
			cfg_q.long_time     <= 16'd2000;
			cfg_q.repeat_delay  <= 16'd0;
			cfg_q.repeat_period <= 16'd500;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_KEY_LEVEL:     cfg_q.key_level     <= pwdata[RegWidth-1:0];
				REG_BOUNCE_TIME:   cfg_q.bounce_time   <= pwdata[RegWidth-1:0];
				REG_LONG_TIME:     cfg_q.long_time     <= pwdata[RegWidth-1:0];
				REG_REPEAT_DELAY:  cfg_q.repeat_delay  <= pwdata[RegWidth-1:0];
				REG_REPEAT_PERIOD: cfg_q.repeat_period <= pwdata[RegWidth-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_KEY_LEVEL:     prdata[RegWidth-1:0] = cfg_q.key_level;
			REG_BOUNCE_TIME:   prdata[RegWidth-1:0] = cfg_q.bounce_time;
			REG_LONG_TIME:     prdata[RegWidth-1:0] = cfg_q.long_time;
			REG_REPEAT_DELAY:  prdata[RegWidth-1:0] = cfg_q.repeat_delay;
			REG_REPEAT_PERIOD: prdata[RegWidth-1:0] = cfg_q.repeat_period;
			default: ;
		endcase
	end

	// The input stage moves on whenever the result register is free or emptying.
	assign advance    = valid_s1 && (!out_valid_q || evt.ready);
	assign poll.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			now_s1   <= poll.now_time;
			level_s1 <= poll.level;
		end
	end

	// Classification of the registered poll.
	bcc_core u_core (
		.cur      (state_q),
		.cfg      (cfg_q),
		.now_time (now_s1),
		.level    (level_s1),
		.nxt      (state_nxt),
		.evt      (event_nxt)
	);

	// Key state advances together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_nxt;
		end
	end

	assign evt.valid     = out_valid_q;
	assign evt.event_res = event_q;

	// Design checks.
`include "button_click_classifier_top_assert.svh"

	`BCC_ASSERT_NOW(a_no_overrun, out_valid_q && !evt.ready && valid_s1, !poll.ready,
		"input stage accepted a poll while its result was blocked")
	`BCC_ASSERT_NOW(a_long_event, $rose(state_q.long_fired),
		out_valid_q && (event_q == EV_LONG), "long press flag set without a long press event")
	`BCC_ASSERT_NOW(a_repeat_stamp, !$stable(state_q.repeat_stamp),
		out_valid_q && (event_q == EV_AUTO), "repeat time moved without an auto repeat event")
	`BCC_ASSERT_NEXT(a_held_step, valid_s1 && !advance, $stable(state_q),
		"key state changed while the input stage was stalled")

endmodule
